// File: src/vector3_arithmetic_unit_core_macros.svh
// Assertion macros for the vector arithmetic core.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef VECTOR3_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define VECTOR3_ARITHMETIC_UNIT_CORE_MACROS_SVH

// same-cycle implication
`define V3AU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define V3AU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/v3au_pkg.sv
// Shared constants, types and the saturation helper for the vector core.
// No dependencies.
package v3au_pkg;
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int STEPS     = WORD_BITS;	// one root / quotient bit per stage

	localparam logic [2:0] MODE_MAG   = 3'd0;
	localparam logic [2:0] MODE_SCALE = 3'd1;
	localparam logic [2:0] MODE_ADD   = 3'd2;
	localparam logic [2:0] MODE_DOT   = 3'd3;
	localparam logic [2:0] MODE_CROSS = 3'd4;
	localparam logic [2:0] MODE_PROJ  = 3'd5;
	localparam logic [2:0] MODE_AREA  = 3'd6;

	localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] WORD_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] val;
		logic        flag;
	} sat_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] rz;
		logic [31:0] rs;
		logic        fs;
		logic        fz;
	} tail_t;

	// clamp a wide signed value to the word range
	function automatic sat_t sat_word(input logic signed [65:0] x);
		sat_t r;
		if (x[65:31] == {35{x[65]}}) begin
			r.val  = x[31:0];
			r.flag = 1'b0;
		end else begin
			r.val  = x[65] ? WORD_MIN : WORD_MAX;
			r.flag = 1'b1;
		end
		return r;
	endfunction
endpackage

// File: src/vector3_arithmetic_unit_core.sv
// Top level of the 3D vector arithmetic core: product, sum, clamp stages,
// then a pipelined square root and three pipelined dividers. Uses v3au_pkg.
//
// channel   ports                                  handshake
// input     mode u_x u_y u_z v_x v_y v_z scale_factor  start && !busy
// result    res_x res_y res_z res_scalar saturated zero_divisor  done (1 cycle)
//
// One transaction per cycle; from accept to done every item passes five
// stages of products, sums, clamps and the projection numerator, the 32
// one-bit root and quotient stages and the output register. busy stays
// low: nothing in the pipe ever waits. Reset clears valid bits, done and flags.
module vector3_arithmetic_unit_core
	import v3au_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         mode,
	input  logic signed [31:0] u_x,
	input  logic signed [31:0] u_y,
	input  logic signed [31:0] u_z,
	input  logic signed [31:0] v_x,
	input  logic signed [31:0] v_y,
	input  logic signed [31:0] v_z,
	input  logic signed [31:0] scale_factor,
	output logic               done,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z,
	output logic signed [31:0] res_scalar,
	output logic               saturated,
	output logic               zero_divisor
);

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------- stage 1: products ----------------
	logic              vld_s1;
	logic [2:0]        mode_s1;
	logic signed [63:0] pu_s1  [3];
	logic signed [63:0] puv_s1 [3];
	logic signed [63:0] pvv_s1 [3];
	logic signed [63:0] pc_s1  [6];
	logic signed [63:0] ps_s1  [3];
	logic signed [32:0] add_s1 [3];
	logic [31:0]        vabs_s1 [3];
	logic               vneg_s1 [3];

	logic signed [31:0] ui [3];
	logic signed [31:0] vi [3];
	assign ui[0] = u_x;
	assign ui[1] = u_y;
	assign ui[2] = u_z;
	assign vi[0] = v_x;
	assign vi[1] = v_y;
	assign vi[2] = v_z;

	always_ff @(posedge clk) begin
		mode_s1  <= mode;
		pc_s1[0] <= 64'(u_y) * 64'(v_z);
		pc_s1[1] <= 64'(u_z) * 64'(v_y);
		pc_s1[2] <= 64'(u_z) * 64'(v_x);
		pc_s1[3] <= 64'(u_x) * 64'(v_z);
		pc_s1[4] <= 64'(u_x) * 64'(v_y);
		pc_s1[5] <= 64'(u_y) * 64'(v_x);
		for (int k = 0; k < 3; k++) begin
			pu_s1[k]   <= 64'(ui[k]) * 64'(ui[k]);
			puv_s1[k]  <= 64'(ui[k]) * 64'(vi[k]);
			pvv_s1[k]  <= 64'(vi[k]) * 64'(vi[k]);
			ps_s1[k]   <= 64'(ui[k]) * 64'(scale_factor);
			add_s1[k]  <= 33'(ui[k]) + 33'(vi[k]);
			vabs_s1[k] <= vi[k][31] ? 32'(-vi[k]) : vi[k];
			vneg_s1[k] <= vi[k][31];
		end
	end

	// ---------------- stage 2: sums ----------------
	logic               vld_s2;
	logic [2:0]         mode_s2;
	logic [63:0]        squ_s2;
	logic signed [65:0] dot_s2;
	logic [63:0]        nn_s2;
	logic signed [64:0] cr_s2  [3];
	logic signed [63:0] ps_s2  [3];
	logic signed [32:0] add_s2 [3];
	logic [31:0]        vabs_s2 [3];
	logic               vneg_s2 [3];

	always_ff @(posedge clk) begin
		mode_s2  <= mode_s1;
		squ_s2   <= 64'(pu_s1[0]) + 64'(pu_s1[1]) + 64'(pu_s1[2]);
		nn_s2    <= 64'(pvv_s1[0]) + 64'(pvv_s1[1]) + 64'(pvv_s1[2]);
		dot_s2   <= 66'(puv_s1[0]) + 66'(puv_s1[1]) + 66'(puv_s1[2]);
		cr_s2[0] <= 65'(pc_s1[0]) - 65'(pc_s1[1]);
		cr_s2[1] <= 65'(pc_s1[2]) - 65'(pc_s1[3]);
		cr_s2[2] <= 65'(pc_s1[4]) - 65'(pc_s1[5]);
		ps_s2    <= ps_s1;
		add_s2   <= add_s1;
		vabs_s2  <= vabs_s1;
		vneg_s2  <= vneg_s1;
	end

	// ---------------- stage 3: shift and clamp ----------------
	logic               vld_s3;
	tail_t              tl_s3;
	logic [63:0]        squ_s3;
	logic [63:0]        nn_s3;
	logic [63:0]        dabs_s3;
	logic               dneg_s3;
	logic signed [31:0] cc_s3   [3];
	logic [31:0]        vabs_s3 [3];
	logic               vneg_s3 [3];

	tail_t              tl_c3;
	sat_t               sc_c3 [3];

	always_comb begin
		sat_t ss [3];
		sat_t sa [3];
		sat_t sd;
		for (int k = 0; k < 3; k++) begin
			ss[k]    = sat_word(66'(ps_s2[k] >>> FRAC_BITS));
			sa[k]    = sat_word(66'(add_s2[k]));
			sc_c3[k] = sat_word(66'(cr_s2[k] >>> FRAC_BITS));
		end
		sd = sat_word(dot_s2 >>> FRAC_BITS);
		tl_c3      = '0;
		tl_c3.mode = mode_s2;
		case (mode_s2)
			MODE_SCALE: begin
				tl_c3.rx = ss[0].val;
				tl_c3.ry = ss[1].val;
				tl_c3.rz = ss[2].val;
				tl_c3.fs = ss[0].flag | ss[1].flag | ss[2].flag;
			end
			MODE_ADD: begin
				tl_c3.rx = sa[0].val;
				tl_c3.ry = sa[1].val;
				tl_c3.rz = sa[2].val;
				tl_c3.fs = sa[0].flag | sa[1].flag | sa[2].flag;
			end
			MODE_DOT: begin
				tl_c3.rs = sd.val;
				tl_c3.fs = sd.flag;
			end
			MODE_CROSS: begin
				tl_c3.rx = sc_c3[0].val;
				tl_c3.ry = sc_c3[1].val;
				tl_c3.rz = sc_c3[2].val;
				tl_c3.fs = sc_c3[0].flag | sc_c3[1].flag | sc_c3[2].flag;
			end
			MODE_AREA: begin
				// area value comes from the root; clamp flags of the cross kept
				tl_c3.fs = sc_c3[0].flag | sc_c3[1].flag | sc_c3[2].flag;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		tl_s3   <= tl_c3;
		squ_s3  <= squ_s2;
		nn_s3   <= nn_s2;
		dneg_s3 <= dot_s2[65];
		dabs_s3 <= dot_s2[65] ? 64'(-dot_s2) : dot_s2[63:0];
		for (int k = 0; k < 3; k++) begin
			cc_s3[k] <= sc_c3[k].val;
		end
		vabs_s3 <= vabs_s2;
		vneg_s3 <= vneg_s2;
	end

	// ---------------- stage 4: area squares, projection partials ----------------
	logic               vld_s4;
	tail_t              tl_s4;
	logic [63:0]        squ_s4;
	logic [63:0]        nn_s4;
	logic signed [63:0] sqc_s4 [3];
	logic [63:0]        ppl_s4 [3];
	logic [63:0]        pph_s4 [3];
	logic               aneg_s4 [3];

	always_ff @(posedge clk) begin
		tl_s4  <= tl_s3;
		squ_s4 <= squ_s3;
		nn_s4  <= nn_s3;
		for (int k = 0; k < 3; k++) begin
			sqc_s4[k]  <= 64'(cc_s3[k]) * 64'(cc_s3[k]);
			ppl_s4[k]  <= 64'(vabs_s3[k]) * 64'(dabs_s3[31:0]);
			pph_s4[k]  <= 64'(vabs_s3[k]) * 64'(dabs_s3[63:32]);
			aneg_s4[k] <= vneg_s3[k] ^ dneg_s3;
		end
	end

	// ---------------- stage 5: radicand and numerators ----------------
	logic        vld_s5;
	tail_t       tl_s5;
	logic [63:0] rad_s5;
	logic [63:0] nn_s5;
	logic [95:0] aabs_s5 [3];
	logic        aneg_s5 [3];

	always_ff @(posedge clk) begin
		tl_s5  <= tl_s4;
		nn_s5  <= nn_s4;
		rad_s5 <= (tl_s4.mode == MODE_AREA)
			? 64'(sqc_s4[0]) + 64'(sqc_s4[1]) + 64'(sqc_s4[2]) : squ_s4;
		for (int k = 0; k < 3; k++) begin
			aabs_s5[k] <= 96'(ppl_s4[k]) + {pph_s4[k], 32'b0};
		end
		aneg_s5 <= aneg_s4;
	end

	// ---------------- stage 6 onward: one root bit and quotient bit per stage ----
	// index 0 is loaded from stage 5, index STEPS feeds the output register
	logic        vld_s6    [STEPS+1];
	tail_t       tl_s6     [STEPS+1];
	logic [33:0] sq_rem_s6 [STEPS+1];
	logic [31:0] sq_rt_s6  [STEPS+1];
	logic [63:0] sq_num_s6 [STEPS+1];
	logic [63:0] nn_s6     [STEPS+1];
	logic        nz_s6     [STEPS+1];
	logic [63:0] dr_s6     [STEPS+1][3];
	logic [31:0] dl_s6     [STEPS+1][3];
	logic [31:0] dq_s6     [STEPS+1][3];
	logic        dneg_s6   [STEPS+1][3];
	logic        dovf_s6   [STEPS+1][3];

	logic [35:0] sq_r2 [STEPS];
	logic [35:0] sq_t  [STEPS];
	logic [64:0] dv_r2 [STEPS][3];

	always_comb begin
		for (int j = 0; j < STEPS; j++) begin
			sq_r2[j] = {sq_rem_s6[j], sq_num_s6[j][63:62]};
			sq_t[j]  = {2'b00, sq_rt_s6[j], 2'b01};
			for (int k = 0; k < 3; k++) begin
				dv_r2[j][k] = {dr_s6[j][k], dl_s6[j][k][31]};
			end
		end
	end

	always_ff @(posedge clk) begin
		tl_s6[0]     <= tl_s5;
		sq_rem_s6[0] <= '0;
		sq_rt_s6[0]  <= '0;
		sq_num_s6[0] <= rad_s5;
		nn_s6[0]     <= nn_s5;
		nz_s6[0]     <= (nn_s5 == 64'd0);
		for (int k = 0; k < 3; k++) begin
			// high part below nn means the quotient fits in one word
			dovf_s6[0][k] <= (aabs_s5[k][95:32] >= nn_s5);
			dr_s6[0][k]   <= aabs_s5[k][95:32];
			dl_s6[0][k]   <= aabs_s5[k][31:0];
			dq_s6[0][k]   <= '0;
			dneg_s6[0][k] <= aneg_s5[k];
		end
		for (int j = 0; j < STEPS; j++) begin
			tl_s6[j+1]     <= tl_s6[j];
			nn_s6[j+1]     <= nn_s6[j];
			nz_s6[j+1]     <= nz_s6[j];
			sq_num_s6[j+1] <= {sq_num_s6[j][61:0], 2'b00};
			if (sq_r2[j] >= sq_t[j]) begin
				sq_rem_s6[j+1] <= 34'(sq_r2[j] - sq_t[j]);
				sq_rt_s6[j+1]  <= {sq_rt_s6[j][30:0], 1'b1};
			end else begin
				sq_rem_s6[j+1] <= sq_r2[j][33:0];
				sq_rt_s6[j+1]  <= {sq_rt_s6[j][30:0], 1'b0};
			end
			for (int k = 0; k < 3; k++) begin
				dl_s6[j+1][k]   <= {dl_s6[j][k][30:0], 1'b0};
				dneg_s6[j+1][k] <= dneg_s6[j][k];
				dovf_s6[j+1][k] <= dovf_s6[j][k];
				if (dv_r2[j][k] >= {1'b0, nn_s6[j]}) begin
					dr_s6[j+1][k] <= 64'(dv_r2[j][k] - {1'b0, nn_s6[j]});
					dq_s6[j+1][k] <= {dq_s6[j][k][30:0], 1'b1};
				end else begin
					dr_s6[j+1][k] <= dv_r2[j][k][63:0];
					dq_s6[j+1][k] <= {dq_s6[j][k][30:0], 1'b0};
				end
			end
		end
	end

	// ---------------- output register ----------------
	tail_t tl_fin;

	always_comb begin
		sat_t        m;
		logic [31:0] pq [3];
		logic        pf [3];
		logic [31:0] q;
		tl_fin = tl_s6[STEPS];
		if (sq_rt_s6[STEPS][31]) begin
			m.val  = WORD_MAX;
			m.flag = 1'b1;
		end else begin
			m.val  = sq_rt_s6[STEPS];
			m.flag = 1'b0;
		end
		for (int k = 0; k < 3; k++) begin
			q = dq_s6[STEPS][k];
			if (dovf_s6[STEPS][k]) begin
				pq[k] = dneg_s6[STEPS][k] ? WORD_MIN : WORD_MAX;
				pf[k] = 1'b1;
			end else if (dneg_s6[STEPS][k]) begin
				// exactly the most negative word is still in range
				if (q[31] && (q[30:0] != 31'd0)) begin
					pq[k] = WORD_MIN;
					pf[k] = 1'b1;
				end else begin
					pq[k] = 32'd0 - q;
					pf[k] = 1'b0;
				end
			end else if (q[31]) begin
				pq[k] = WORD_MAX;
				pf[k] = 1'b1;
			end else begin
				pq[k] = q;
				pf[k] = 1'b0;
			end
		end
		case (tl_fin.mode)
			MODE_MAG: begin
				tl_fin.rs = m.val;
				tl_fin.fs = m.flag;
			end
			MODE_AREA: begin
				tl_fin.rs = m.val;
				tl_fin.fs = tl_fin.fs | m.flag;
			end
			MODE_PROJ: begin
				if (nz_s6[STEPS]) begin
					tl_fin.fz = 1'b1;
				end else begin
					tl_fin.rx = pq[0];
					tl_fin.ry = pq[1];
					tl_fin.rz = pq[2];
					tl_fin.fs = pf[0] | pf[1] | pf[2];
				end
			end
			default: begin
			end
		endcase
	end

	logic        done_q;
	logic [31:0] rx_q, ry_q, rz_q, rs_q;
	logic        fs_q, fz_q;

	always_ff @(posedge clk) begin
		rx_q <= tl_fin.rx;
		ry_q <= tl_fin.ry;
		rz_q <= tl_fin.rz;
		rs_q <= tl_fin.rs;
	end

	// valid bits and flags that qualify the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			for (int j = 0; j <= STEPS; j++) begin
				vld_s6[j] <= 1'b0;
			end
			done_q <= 1'b0;
			fs_q   <= 1'b0;
			fz_q   <= 1'b0;
		end else begin
			vld_s1    <= accept;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6[0] <= vld_s5;
			for (int j = 0; j < STEPS; j++) begin
				vld_s6[j+1] <= vld_s6[j];
			end
			done_q <= vld_s6[STEPS];
			fs_q   <= vld_s6[STEPS] & tl_fin.fs;
			fz_q   <= vld_s6[STEPS] & tl_fin.fz;
		end
	end

	assign done         = done_q;
	assign res_x        = rx_q;
	assign res_y        = ry_q;
	assign res_z        = rz_q;
	assign res_scalar   = rs_q;
	assign saturated    = fs_q;
	assign zero_divisor = fz_q;

	// ---------------- assertions ----------------
`include "vector3_arithmetic_unit_core_macros.svh"

	`V3AU_ASSERT_IMP(a_zdiv_clean, zero_divisor, done && !saturated && res_x == 0 && res_y == 0 && res_z == 0 && res_scalar == 0, "zero divisor result not clean")
	`V3AU_ASSERT_IMP(a_root_rem, vld_s6[STEPS], sq_rem_s6[STEPS] <= {1'b0, sq_rt_s6[STEPS], 1'b0}, "root remainder out of bound")
	`V3AU_ASSERT_NXT(a_mag_vec_zero, vld_s6[STEPS] && tl_s6[STEPS].mode == MODE_MAG, done && res_x == 0 && res_y == 0 && res_z == 0, "magnitude result has vector part")
	`V3AU_ASSERT_IMP(a_flag_strobe, saturated || zero_divisor, done, "flag without strobe")

endmodule
